@@ hw/rtl/sqa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqa_pkg
// Shared types, widths and constants of the signed angle about axis block.
// ----------------------------------------------------------------------------
package sqa_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int unsigned VEC_W   = 32;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned PROJ_W  = 40;
  localparam int unsigned NRM_W   = 16;
  localparam int unsigned CRS_W   = 34;
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 34;
  localparam int unsigned ACC_W   = 72;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned XY_W    = 36;
  localparam int unsigned Z_W     = 34;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned ATAN_N  = 24;
  localparam int unsigned ATAN_IW = 5;

  localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 16'sd25736;
  localparam logic signed [ACC_W-1:0] NEG_ONE_Q16 = -72'sd65536;
  localparam logic signed [AXIS_W-1:0] AXIS_Z_RST = 16'sd16384;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_AXIS_X = 2'd1,
    REG_AXIS_Y = 2'd2,
    REG_AXIS_Z = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT,
    S_OFF,
    S_CHK,
    S_NORM,
    S_CROSS,
    S_MACS,
    S_SQST,
    S_SQW,
    S_CDST,
    S_CDW,
    S_OUT
  } st_e;

  typedef struct packed {
    logic vld;
    logic clr;
    logic neg;
  } mac_ctl_t;

  function automatic logic [29:0] atan_q30(input logic [ATAN_IW-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd843314856;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525158;
      5'd4:    v = 30'd67021686;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194282;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048575;
      5'd11:   v = 30'd524287;
      5'd12:   v = 30'd262143;
      5'd13:   v = 30'd131071;
      5'd14:   v = 30'd65535;
      5'd15:   v = 30'd32767;
      5'd16:   v = 30'd16383;
      5'd17:   v = 30'd8191;
      5'd18:   v = 30'd4095;
      5'd19:   v = 30'd2047;
      5'd20:   v = 30'd1023;
      5'd21:   v = 30'd511;
      5'd22:   v = 30'd255;
      5'd23:   v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/signed_angle_about_axis.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signed_angle_about_axis
// Tracks control points and reports their signed rotation about an axis.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result item. With the block
// inactive the item goes straight to the output state, and the next item can
// be taken once the block is back in idle, which it reaches as the result is
// registered. Otherwise each point is projected and normalized by shifts,
// then the cross product, square root and CORDIC follow; a zero projection or
// cross product sends the item to the output early. The shared multiplier
// runs 27 products in sequence before the square root and the CORDIC.
module signed_angle_about_axis #(
  parameter int unsigned COORD_WIDTH  = sqa_pkg::COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = sqa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sqa_pkg::ANG_W-1:0]    angle_o,
  output logic                                degenerate_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [sqa_pkg::AXIS_W-1:0]          cfg_data_i
);
  import sqa_pkg::*;

  localparam int unsigned SW  = (COORD_WIDTH > VEC_W) ? COORD_WIDTH : VEC_W;
  localparam int unsigned PRE = (COORD_WIDTH > VEC_W) ? COORD_WIDTH - VEC_W : 0;

  st_e                     state_q, state_d;
  logic [3:0]              cnt_q, cnt_d;
  logic                    sel_q, sel_d;
  logic                    active_q, pick_q;
  logic signed [AXIS_W-1:0] axis_q [3];
  logic signed [SW-1:0]    ref_q [3];
  logic signed [SW-1:0]    cur_q [3];
  logic signed [SW-1:0]    pin_w [3];
  logic signed [VEC_W-1:0] v_w [3];
  logic signed [35:0]      d_q;
  logic signed [PROJ_W-1:0] o_q [3];
  logic [PROJ_W-1:0]       abs_w [3];
  logic [PROJ_W-1:0]       mx_w, m_q;
  logic signed [NRM_W-1:0] r_q [3];
  logic signed [NRM_W-1:0] q_q [3];
  logic signed [CRS_W-1:0] c_q [3];
  logic [SQ_W-1:0]         sq_q;
  logic signed [CRS_W-1:0] x_q;
  logic                    neg_q;
  logic                    in_acc_w, out_free_w, zero_w, nrm_ok_w;
  logic [1:0]              k_w;
  logic signed [ANG_W-1:0] pend_ang_q;
  logic                    pend_deg_q;
  logic                    out_valid_q, degen_q;
  logic signed [ANG_W-1:0] angle_q;

  mac_ctl_t                 mctl_w;
  logic signed [MUL_A_W-1:0] ma_w;
  logic signed [MUL_B_W-1:0] mb_w;
  logic signed [ACC_W-1:0]  acc_w;
  logic signed [ACC_W-1:0]  accs_w;

  logic                    sq_done_w, cd_done_w;
  logic [ROOT_W-1:0]       root_w;
  logic signed [XY_W-1:0]  cy_w;
  logic signed [ANG_W-1:0] cang_w;

  assign in_acc_w   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free_w = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign angle_o      = angle_q;
  assign degenerate_o = degen_q;

  assign pin_w[0] = SW'(point_x_i);
  assign pin_w[1] = SW'(point_y_i);
  assign pin_w[2] = SW'(point_z_i);

  assign accs_w = acc_w >>> 14;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_w[i]   = VEC_W'((sel_q ? cur_q[i] : ref_q[i]) >>> PRE);
      abs_w[i] = (o_q[i] < 0) ? PROJ_W'(-o_q[i]) : PROJ_W'(o_q[i]);
    end
    mx_w = abs_w[0];
    if (abs_w[1] > mx_w) begin
      mx_w = abs_w[1];
    end
    if (abs_w[2] > mx_w) begin
      mx_w = abs_w[2];
    end
  end

  assign zero_w   = (o_q[0] == '0) && (o_q[1] == '0) && (o_q[2] == '0);
  assign nrm_ok_w = (m_q <= PROJ_W'(32767)) && (m_q >= PROJ_W'(16384));

  always_comb begin
    if (cnt_q < 4'd3) begin
      k_w = cnt_q[1:0];
    end else if (cnt_q < 4'd6) begin
      k_w = 2'(cnt_q - 4'd3);
    end else begin
      k_w = 2'(cnt_q - 4'd6);
    end
  end

  always_comb begin
    mctl_w = '0;
    ma_w   = '0;
    mb_w   = '0;
    case (state_q)
      S_DOT: begin
        mctl_w.vld = (cnt_q < 4'd3);
        mctl_w.clr = (cnt_q == 4'd0);
        ma_w = MUL_A_W'(v_w[k_w]);
        mb_w = MUL_B_W'(axis_q[k_w]);
      end
      S_OFF: begin
        mctl_w.vld = (cnt_q < 4'd3);
        mctl_w.clr = 1'b1;
        ma_w = MUL_A_W'(d_q);
        mb_w = MUL_B_W'(axis_q[k_w]);
      end
      S_CROSS: begin
        mctl_w.vld = (cnt_q < 4'd6);
        mctl_w.clr = !cnt_q[0];
        mctl_w.neg = cnt_q[0];
        case (cnt_q)
          4'd0: begin ma_w = MUL_A_W'(r_q[1]); mb_w = MUL_B_W'(q_q[2]); end
          4'd1: begin ma_w = MUL_A_W'(r_q[2]); mb_w = MUL_B_W'(q_q[1]); end
          4'd2: begin ma_w = MUL_A_W'(r_q[2]); mb_w = MUL_B_W'(q_q[0]); end
          4'd3: begin ma_w = MUL_A_W'(r_q[0]); mb_w = MUL_B_W'(q_q[2]); end
          4'd4: begin ma_w = MUL_A_W'(r_q[0]); mb_w = MUL_B_W'(q_q[1]); end
          4'd5: begin ma_w = MUL_A_W'(r_q[1]); mb_w = MUL_B_W'(q_q[0]); end
          default: begin ma_w = '0; mb_w = '0; end
        endcase
      end
      S_MACS: begin
        mctl_w.vld = (cnt_q < 4'd9);
        mctl_w.clr = (cnt_q == 4'd0) || (cnt_q == 4'd3) || (cnt_q == 4'd6);
        if (cnt_q < 4'd3) begin
          ma_w = MUL_A_W'(c_q[k_w]);
          mb_w = MUL_B_W'(c_q[k_w]);
        end else if (cnt_q < 4'd6) begin
          ma_w = MUL_A_W'(r_q[k_w]);
          mb_w = MUL_B_W'(q_q[k_w]);
        end else begin
          ma_w = MUL_A_W'(c_q[k_w]);
          mb_w = MUL_B_W'(axis_q[k_w]);
        end
      end
      default: begin
        mctl_w = '0;
      end
    endcase
  end

  sqa_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl_w),
    .a_i    (ma_w),
    .b_i    (mb_w),
    .acc_o  (acc_w)
  );

  sqa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_SQST) && (sq_q != '0)),
    .n_i     (sq_q),
    .done_o  (sq_done_w),
    .root_o  (root_w)
  );

  assign cy_w = neg_q ? -XY_W'({1'b0, root_w}) : XY_W'({1'b0, root_w});

  sqa_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_CDST),
    .x_i     (XY_W'(x_q)),
    .y_i     (cy_w),
    .done_o  (cd_done_w),
    .angle_o (cang_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 4'd1;
    sel_d   = sel_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        sel_d = 1'b0;
        if (in_acc_w) begin
          state_d = active_q ? S_DOT : S_OUT;
        end
      end
      S_DOT: begin
        if (cnt_q == 4'd4) begin
          state_d = S_OFF;
          cnt_d   = '0;
        end
      end
      S_OFF: begin
        if (cnt_q == 4'd4) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = zero_w ? S_OUT : S_NORM;
      end
      S_NORM: begin
        cnt_d = '0;
        if (nrm_ok_w) begin
          state_d = sel_q ? S_CROSS : S_DOT;
          sel_d   = 1'b1;
        end
      end
      S_CROSS: begin
        if (cnt_q == 4'd7) begin
          state_d = S_MACS;
          cnt_d   = '0;
        end
      end
      S_MACS: begin
        if (cnt_q == 4'd10) begin
          state_d = S_SQST;
        end
      end
      S_SQST: begin
        state_d = (sq_q == '0) ? S_OUT : S_SQW;
      end
      S_SQW: begin
        if (sq_done_w) begin
          state_d = S_CDST;
        end
      end
      S_CDST: begin
        state_d = S_CDW;
      end
      S_CDW: begin
        if (cd_done_w) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free_w) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= AXIS_Z_RST;
      pick_q    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ref_q[i] <= (i == 1) ? SW'(NEG_ONE_Q16) : '0;
        cur_q[i] <= (i == 1) ? SW'(NEG_ONE_Q16) : '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_ACTIVE: active_q  <= cfg_data_i[0];
          REG_AXIS_X: axis_q[0] <= cfg_data_i;
          REG_AXIS_Y: axis_q[1] <= cfg_data_i;
          REG_AXIS_Z: axis_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc_w) begin
        if (!mode_i) begin
          pick_q <= active_q;
        end else if (active_q) begin
          for (int i = 0; i < 3; i++) begin
            ref_q[i] <= pick_q ? pin_w[i] : cur_q[i];
            cur_q[i] <= pin_w[i];
          end
          pick_q <= 1'b0;
        end
      end
      if ((state_q == S_OUT) && out_free_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        pend_ang_q <= '0;
        pend_deg_q <= 1'b1;
      end
      S_DOT: begin
        if (cnt_q == 4'd4) begin
          d_q <= 36'(accs_w);
        end
      end
      S_OFF: begin
        if (cnt_q >= 4'd2) begin
          o_q[2'(cnt_q - 4'd2)] <= PROJ_W'(v_w[2'(cnt_q - 4'd2)]) - PROJ_W'(accs_w);
        end
      end
      S_CHK: begin
        m_q <= mx_w;
      end
      S_NORM: begin
        if (m_q > PROJ_W'(32767)) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) begin
            o_q[i] <= o_q[i] >>> 1;
          end
        end else if (m_q < PROJ_W'(16384)) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) begin
            o_q[i] <= o_q[i] <<< 1;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (sel_q) begin
              q_q[i] <= o_q[i][NRM_W-1:0];
            end else begin
              r_q[i] <= o_q[i][NRM_W-1:0];
            end
          end
        end
      end
      S_CROSS: begin
        if ((cnt_q == 4'd3) || (cnt_q == 4'd5) || (cnt_q == 4'd7)) begin
          c_q[2'(cnt_q[2:1] - 2'd1)] <= CRS_W'(acc_w);
        end
      end
      S_MACS: begin
        if (cnt_q == 4'd4) begin
          sq_q <= SQ_W'(acc_w);
        end
        if (cnt_q == 4'd7) begin
          x_q <= CRS_W'(acc_w);
        end
        if (cnt_q == 4'd10) begin
          neg_q <= (acc_w < 0);
        end
      end
      S_CDW: begin
        if (cd_done_w) begin
          pend_ang_q <= cang_w;
          pend_deg_q <= 1'b0;
        end
      end
      S_OUT: begin
        if (out_free_w) begin
          angle_q <= pend_ang_q;
          degen_q <= pend_deg_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/sqa_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqa_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module sqa_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sqa_pkg::mac_ctl_t                     ctl_i,
  input  logic signed [sqa_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [sqa_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [sqa_pkg::ACC_W-1:0]      acc_o
);
  import sqa_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] prod_w;
  logic signed [ACC_W-1:0]           prod_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic signed [ACC_W-1:0]           base_w;
  mac_ctl_t                          ctl_q;

  assign prod_w = a_i * b_i;
  assign base_w = ctl_q.clr ? '0 : acc_q;
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ACC_W'(prod_w);
    if (ctl_q.vld) begin
      acc_q <= ctl_q.neg ? base_w - prod_q : base_w + prod_q;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sqa_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqa_isqrt
// Bit-pair restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sqa_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sqa_pkg::SQ_W-1:0]       n_i,
  output logic                           done_o,
  output logic [sqa_pkg::ROOT_W-1:0]     root_o
);
  import sqa_pkg::*;

  logic [SQ_W-1:0] rem_q;
  logic [SQ_W-1:0] res_q;
  logic [SQ_W-1:0] bit_q;
  logic [SQ_W-1:0] trial_w;
  logic            busy_q;
  logic            done_q;

  assign trial_w = res_q + bit_q;
  assign done_o  = done_q;
  assign root_o  = res_q[ROOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (bit_q == SQ_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q == SQ_W'(1))) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= n_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (rem_q >= trial_w) begin
        rem_q <= rem_q - trial_w;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sqa_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqa_cordic
// Serial vectoring CORDIC giving atan2 in Q3.13 radians.
// ----------------------------------------------------------------------------
module sqa_cordic #(
  parameter int unsigned CORDIC_STEPS = sqa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sqa_pkg::XY_W-1:0]     x_i,
  input  logic signed [sqa_pkg::XY_W-1:0]     y_i,
  output logic                                done_o,
  output logic signed [sqa_pkg::ANG_W-1:0]    angle_o
);
  import sqa_pkg::*;

  localparam int unsigned NSTEP = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;

  logic signed [XY_W-1:0]  x_q, y_q, xs_w, ys_w;
  logic signed [Z_W-1:0]   z_q, at_w, zr_w;
  logic [ATAN_IW-1:0]      i_q;
  logic                    busy_q, done_q, last_w;

  assign xs_w   = x_q >>> i_q;
  assign ys_w   = y_q >>> i_q;
  assign at_w   = Z_W'(atan_q30(i_q));
  assign last_w = (i_q == ATAN_IW'(NSTEP - 1));
  assign zr_w   = (z_q + Z_W'(65536)) >>> 17;
  assign done_o = done_q;

  always_comb begin
    if (zr_w > Z_W'(ANGLE_LIMIT)) begin
      angle_o = ANGLE_LIMIT;
    end else if (zr_w < -Z_W'(ANGLE_LIMIT)) begin
      angle_o = -ANGLE_LIMIT;
    end else begin
      angle_o = zr_w[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last_w;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last_w) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      i_q <= '0;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= y_i;
          y_q <= -x_i;
          z_q <= HALF_PI_Q30;
        end else begin
          x_q <= -y_i;
          y_q <= x_i;
          z_q <= -HALF_PI_Q30;
        end
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (y_q > 0) begin
        x_q <= x_q + ys_w;
        y_q <= y_q - xs_w;
        z_q <= z_q + at_w;
      end else begin
        x_q <= x_q - ys_w;
        y_q <= y_q + xs_w;
        z_q <= z_q - at_w;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sqa_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sqa_chk
// Port-level checks of the signed angle about axis block.
// ----------------------------------------------------------------------------
module sqa_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] angle_o,
  input logic               degenerate_o
);

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a second item without a busy period");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(angle_o) && $stable(degenerate_o)))
    else $error("stalled result item changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (angle_o == 16'sd0))
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((angle_o <= 16'sd25736) && (angle_o >= -16'sd25736)))
    else $error("angle outside clamp range");

endmodule

bind signed_angle_about_axis sqa_chk u_sqa_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .angle_o      (angle_o),
  .degenerate_o (degenerate_o)
);
`default_nettype wire

@@ verif/tb_signed_angle_about_axis.sv @@
// ----------------------------------------------------------------------------
// tb_signed_angle_about_axis
// Self-checking testbench of the signed angle about axis block. A queue-fed
// driver offers picks and control points with random gaps, a monitor checks
// every result item against a predictor of the projection, cross product,
// square root and CORDIC path, and the axis and enable are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_signed_angle_about_axis;
  timeunit 1ns;
  timeprecision 1ps;
  import sqa_pkg::*;

  localparam logic MODE_PICK = 1'b0;
  localparam logic MODE_POINT = 1'b1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;
  localparam longint ANG_MAX = 25736;
  localparam longint HALF_PI = 1686629713;

  typedef longint vec_t[3];
  typedef struct {
    logic mode;
    logic signed [31:0] p[3];
  } point_item_t;
  typedef struct {
    logic signed [15:0] angle;
    logic degen;
  } angle_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] angle_o;
  logic degenerate_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  signed_angle_about_axis dut (.*);

  point_item_t pending_items[$];
  angle_res_t expected_angles[$];
  point_item_t driven_item;
  int errors = 0;
  int cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  logic no_idle = 1'b0;
  logic rx_hold = 1'b0;

  logic en_active;
  longint axis[3];
  vec_t ref_pt, cur_pt;
  logic pick_armed;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_signed_angle_about_axis NOT OK");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint iabs(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic project_normalize(input vec_t p, output vec_t o);
    longint d, m;
    int k;
    m = 0;
    k = 0;
    d = floor_shr(p[0] * axis[0] + p[1] * axis[1] + p[2] * axis[2], 14);
    for (int i = 0; i < 3; i++) begin
      o[i] = p[i] - floor_shr(axis[i] * d, 14);
      if (iabs(o[i]) > m) m = iabs(o[i]);
    end
    if (m == 0) return 1'b0;
    while (m > 32767) begin
      m >>= 1;
      k++;
    end
    if (k > 0) begin
      for (int i = 0; i < 3; i++) o[i] = floor_shr(o[i], k);
    end else begin
      while (m < 16384) begin
        m <<= 1;
        k++;
      end
      for (int i = 0; i < 3; i++) o[i] = o[i] * (64'sd1 <<< k);
    end
    return 1'b1;
  endfunction

  function automatic angle_res_t rotation_angle();
    angle_res_t res;
    vec_t r, q;
    longint c[3];
    longint x, y, z, s, xo;
    longint unsigned sq;
    res.angle = '0;
    res.degen = 1'b1;
    if (!en_active) return res;
    if (!project_normalize(ref_pt, r)) return res;
    if (!project_normalize(cur_pt, q)) return res;
    c[0] = r[1] * q[2] - r[2] * q[1];
    c[1] = r[2] * q[0] - r[0] * q[2];
    c[2] = r[0] * q[1] - r[1] * q[0];
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(iabs(c[i])) * longint'(iabs(c[i]));
    if (sq == 0) return res;
    x = r[0] * q[0] + r[1] * q[1] + r[2] * q[2];
    y = longint'(int_sqrt(sq));
    s = axis[0] * c[0] + axis[1] * c[1] + axis[2] * c[2];
    if (s < 0) y = -y;
    z = 0;
    if (x < 0) begin
      xo = x;
      if (y >= 0) begin
        x = y;
        y = -xo;
        z = HALF_PI;
      end else begin
        x = -y;
        y = xo;
        z = -HALF_PI;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_N; i++) begin
      xo = x;
      if (y > 0) begin
        x += floor_shr(y, i);
        y -= floor_shr(xo, i);
        z += longint'(atan_q30(ATAN_IW'(i)));
      end else begin
        x -= floor_shr(y, i);
        y += floor_shr(xo, i);
        z -= longint'(atan_q30(ATAN_IW'(i)));
      end
    end
    z = floor_shr(z + 65536, 17);
    if (z > ANG_MAX) z = ANG_MAX;
    if (z < -ANG_MAX) z = -ANG_MAX;
    res.angle = 16'(z);
    res.degen = 1'b0;
    return res;
  endfunction

  task automatic track_item(input point_item_t it);
    if (it.mode == MODE_PICK) begin
      pick_armed = en_active;
    end else if (en_active) begin
      for (int i = 0; i < 3; i++) begin
        ref_pt[i] = pick_armed ? longint'(it.p[i]) : cur_pt[i];
        cur_pt[i] = longint'(it.p[i]);
      end
      pick_armed = 1'b0;
    end
    expected_angles.push_back(rotation_angle());
  endtask

  always @(posedge clk_i) begin : drive
    point_item_t it;
    logic accepted;
    accepted = in_valid_i && !in_stall_o;
    if (accepted) track_item(driven_item);
    if (rst_ni && (!in_valid_i || accepted)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        driven_item = it;
        mode_i <= it.mode;
        point_x_i <= it.p[0];
        point_y_i <= it.p[1];
        point_z_i <= it.p[2];
        in_valid_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    angle_res_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_angles.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        e = expected_angles.pop_front();
        if (angle_o !== e.angle)
          report($sformatf("angle %0d, expected %0d", angle_o, e.angle));
        if (degenerate_o !== e.degen)
          report($sformatf("degenerate %0b, expected %0b", degenerate_o, e.degen));
      end
    end
    if (rx_hold) begin
      out_stall_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic add_item(input logic mode, input longint x, input longint y, input longint z);
    point_item_t it;
    it.mode = mode;
    it.p[0] = 32'(x);
    it.p[1] = 32'(y);
    it.p[2] = 32'(z);
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_angles.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_ACTIVE: en_active = val[0];
      REG_AXIS_X: axis[0] = longint'($signed(val));
      REG_AXIS_Y: axis[1] = longint'($signed(val));
      REG_AXIS_Z: axis[2] = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return longint'($signed($urandom));
      2: return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      3: return (longint'($urandom_range(0, 64)) - 32) * 65536;
      4: return 0;
      default: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
    endcase
  endfunction

  task automatic random_items(input int n);
    point_item_t last;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(MODE_PICK, rand_coord(), rand_coord(), rand_coord());
      end else if ($urandom_range(0, 19) == 0 && pending_items.size() > 0) begin
        last = pending_items[$];
        add_item(MODE_POINT, last.p[0], last.p[1], last.p[2]);
      end else begin
        add_item(MODE_POINT, rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    en_active = 1'b0;
    axis[0] = 0;
    axis[1] = 0;
    axis[2] = 16384;
    for (int i = 0; i < 3; i++) begin
      ref_pt[i] = 0;
      cur_pt[i] = 0;
    end
    ref_pt[1] = -65536;
    cur_pt[1] = -65536;
    pick_armed = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_item(MODE_POINT, 65536, 0, 0);
    add_item(MODE_PICK, 0, 0, 0);
    add_item(MODE_POINT, 0, 65536, 0);
    wait_idle();

    write_reg(REG_ACTIVE, 16'd1);
    add_item(MODE_POINT, 65536, 0, 0);
    add_item(MODE_POINT, 0, 65536, 0);
    add_item(MODE_POINT, -65536, 0, 0);
    add_item(MODE_POINT, 65536, 0, 0);
    add_item(MODE_PICK, 0, 0, 0);
    add_item(MODE_POINT, 3 * 65536, 4 * 65536, 7);
    add_item(MODE_POINT, -3 * 65536, 4 * 65536, 0);
    add_item(MODE_POINT, 0, 0, 65536);
    add_item(MODE_POINT, 65536, 65536, 0);
    add_item(MODE_POINT, 2147483647, 2147483647, 2147483647);
    add_item(MODE_POINT, -2147483648, -2147483648, -2147483648);
    add_item(MODE_POINT, 2147483647, -2147483648, 0);
    add_item(MODE_POINT, 1, 0, 0);
    add_item(MODE_POINT, 0, -1, 0);
    add_item(MODE_POINT, -65536, -65536, 0);
    add_item(MODE_POINT, 65536, -65536, 5);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_AXIS_X, 16'h8000);
          write_reg(REG_AXIS_Y, 16'h0000);
          write_reg(REG_AXIS_Z, 16'h0000);
        end
        1: begin
          write_reg(REG_AXIS_X, 16'h7fff);
          write_reg(REG_AXIS_Y, 16'h7fff);
          write_reg(REG_AXIS_Z, 16'h7fff);
        end
        2: begin
          write_reg(REG_AXIS_X, 16'h8000);
          write_reg(REG_AXIS_Y, 16'h8000);
          write_reg(REG_AXIS_Z, 16'h8000);
        end
        3: write_reg(REG_ACTIVE, 16'd0);
        4: begin
          write_reg(REG_ACTIVE, 16'd1);
          write_reg(REG_AXIS_X, 16'd0);
          write_reg(REG_AXIS_Y, 16'd16384);
          write_reg(REG_AXIS_Z, 16'd0);
        end
        7: begin
          write_reg(REG_AXIS_X, 16'd0);
          write_reg(REG_AXIS_Y, 16'd0);
          write_reg(REG_AXIS_Z, 16'd16384);
          no_idle = 1'b1;
        end
        default: begin
          write_reg(REG_AXIS_X, 16'($urandom));
          write_reg(REG_AXIS_Y, 16'($urandom));
          write_reg(REG_AXIS_Z, 16'($urandom));
        end
      endcase
      if (ph == 1) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (600) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      add_item(MODE_PICK, 0, 0, 0);
      random_items(ph == 3 ? 100 : 240);
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_signed_angle_about_axis OK");
    end else begin
      $display("tb_signed_angle_about_axis NOT OK");
    end
    $finish;
  end
endmodule
